// ===== src/multi_waveform_oscillator_top_macros.svh =====
// Assertion macros shared by the oscillator checker.
`ifndef MULTI_WAVEFORM_OSCILLATOR_TOP_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MWO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oscillator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MWO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oscillator check failed");

`endif

// ===== src/mwo_pkg.sv =====
// Shared types, constants and table functions for the oscillator.
package mwo_pkg;

  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned WAVE_W   = 3;
  localparam int unsigned PW_W     = 16;
  localparam int unsigned HZ_W     = 24;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned ROM_W    = 15;

  localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_RISE   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_FALL   = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd4;

  localparam logic [CFG_AW-1:0] REG_WAVE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PULSE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_STEP  = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_RST  = WAVE_SINE;
  localparam logic [PW_W-1:0]   PW_RST    = 16'd32768;
  localparam logic [PW_W-1:0]   PW_MIN    = 16'd655;
  localparam logic [PW_W-1:0]   PW_MAX    = 16'd64880;
  localparam logic [HZ_W-1:0]   HZ_RST    = 24'd1558265;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = -16'sd32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam int unsigned TAYLOR_DIV [1:10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef struct packed {
    logic [WAVE_W-1:0] wave_type;
    logic [PW_W-1:0]   pulse_width;
    logic [HZ_W-1:0]   hz_to_step;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] phase;
  } ph_stage_t;

  // Quarter-wave entry k of a 2**bits table, Q30 Taylor series, full scale 32767.
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (64'(k) * HALF_PI_Q30) >> bits;
    term = x;
    sum  = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'(TAYLOR_DIV[n]);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[ROM_W-1:0];
  endfunction

  // round(u * 32767 / 2**31) - 32767, halves upward, u in 0..2**32.
  function automatic logic signed [SAMPLE_W-1:0] scale_u33(input logic [32:0] u);
    logic [48:0] prod;
    logic [16:0] lvl;
    prod = ({16'b0, u} << 15) - {16'b0, u} + (49'd1 << 30);
    lvl  = prod[47:31] - 17'd32767;
    return lvl[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== src/mwo_if.sv =====
// Channel interfaces: frequency input, sample output and register writes.
interface mwo_in_if;
  import mwo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FREQ_W-1:0] frequency;
  modport source (output valid, output frequency, input ready);
  modport sink (input valid, input frequency, output ready);
endinterface

interface mwo_out_if;
  import mwo_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mwo_cfg_if;
  import mwo_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== src/multi_waveform_oscillator_top.sv =====
// Top level of the multi-waveform phase-accumulator oscillator.
//
// Channels: in_bus carries a request with a signed frequency in 1/16 Hz;
// out_bus returns one signed 16-bit sample per request, the waveform at
// the phase before that request's step is added. cfg_bus writes the
// registers: 0 wave type, 1 pulse width (clamped 655..64880), 2 hz_to_step.
// cfg_bus.ready is always high; write only while no request is in flight.
// A request accepted on in_bus has its sample on out_bus after passing
// through three register stages (input, phase, result).
// Throughput: one request per cycle while out_bus is not stalled; the 32-bit
// accumulate step and the registered sine ROM read each sit in a stage of their own.
// Reset (synchronous, rst_n low) clears the phase to zero, empties all
// stages and restores sine, half duty and the 44.1 kHz step factor.
// A stalled out_bus holds its sample; upstream stages keep filling until
// all three are full, then in_bus.ready drops.
module multi_waveform_oscillator_top #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  mwo_in_if.sink    in_bus,
  mwo_out_if.source out_bus,
  mwo_cfg_if.sink   cfg_bus
);
  import mwo_pkg::*;

  logic [WAVE_W-1:0] wave_r;
  logic [PW_W-1:0]   pw_r;
  logic [HZ_W-1:0]   hz_r;
  logic [PW_W-1:0]   pw_nxt;
  logic              take;
  cfg_t              cfg;
  ph_stage_t         ph_stage;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    pw_nxt = cfg_bus.data[PW_W-1:0];
    if (pw_nxt < PW_MIN) begin
      pw_nxt = PW_MIN;
    end else if (pw_nxt > PW_MAX) begin
      pw_nxt = PW_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= WAVE_RST;
      pw_r   <= PW_RST;
      hz_r   <= HZ_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.addr)
        REG_WAVE:  wave_r <= cfg_bus.data[WAVE_W-1:0];
        REG_PULSE: pw_r   <= pw_nxt;
        REG_STEP:  hz_r   <= cfg_bus.data[HZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.wave_type   = wave_r;
  assign cfg.pulse_width = pw_r;
  assign cfg.hz_to_step  = hz_r;

  mwo_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_frequency (in_bus.frequency),
    .hz_to_step   (cfg.hz_to_step),
    .take         (take),
    .ph_stage     (ph_stage)
  );

  mwo_shaper #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shaper (
    .clk        (clk),
    .rst_n      (rst_n),
    .ph_stage   (ph_stage),
    .cfg        (cfg),
    .take       (take),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_sample (out_bus.sample)
  );
endmodule

// ===== src/mwo_sine_rom.sv =====
// Quarter-wave sine ROM with registered read, contents built at elaboration.
module mwo_sine_rom #(
  parameter int unsigned TBL_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [TBL_BITS:0]           rd_addr,
  output logic [mwo_pkg::ROM_W-1:0]   rd_data
);
  import mwo_pkg::*;

  localparam int unsigned DEPTH = (2 ** TBL_BITS) + 1;

  typedef logic [ROM_W-1:0] rom_arr_t [DEPTH];

  function automatic rom_arr_t build_rom();
    rom_arr_t tbl;
    for (int k = 0; k < DEPTH; k++) begin
      tbl[k] = sine_entry(k, TBL_BITS);
    end
    return tbl;
  endfunction

  localparam rom_arr_t ROM_TABLE = build_rom();

  logic [ROM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_TABLE[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== src/mwo_phase.sv =====
// Input register, phase accumulator and phase stage.
module mwo_phase (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [mwo_pkg::FREQ_W-1:0] in_frequency,
  input  logic [mwo_pkg::HZ_W-1:0]        hz_to_step,
  input  logic                            take,
  output mwo_pkg::ph_stage_t              ph_stage
);
  import mwo_pkg::*;

  logic                     v1_r, v1_nxt;
  logic signed [FREQ_W-1:0] f1_r;
  logic                     v2_r;
  logic [PHASE_W-1:0]       ph2_r;
  logic [PHASE_W-1:0]       acc_r, acc_nxt;
  logic                     s2_free;
  logic                     move12;
  logic                     accept;
  logic signed [FREQ_W+HZ_W:0] prod;

  assign s2_free  = !v2_r || take;
  assign move12   = v1_r && s2_free;
  assign in_ready = !v1_r || s2_free;
  assign accept   = in_valid && in_ready;
  assign v1_nxt   = accept || (v1_r && !s2_free);

  // floor((f * hz) / 256), low 32 bits
  assign prod    = $signed(f1_r) * $signed({1'b0, hz_to_step});
  assign acc_nxt = acc_r + prod[PHASE_W+7:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= v1_nxt;
      if (s2_free) begin
        v2_r <= v1_r;
      end
      if (move12) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_r <= in_frequency;
    end
    if (move12) begin
      ph2_r <= acc_r;
    end
  end

  assign ph_stage.valid = v2_r;
  assign ph_stage.phase = ph2_r;
endmodule

// ===== src/mwo_shaper.sv =====
// Waveform shaping from phase, sine lookup and result register.
module mwo_shaper #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mwo_pkg::ph_stage_t                ph_stage,
  input  mwo_pkg::cfg_t                     cfg,
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mwo_pkg::SAMPLE_W-1:0] out_sample
);
  import mwo_pkg::*;

  localparam int unsigned N = SINE_TABLE_BITS;

  logic [PHASE_W-1:0]         ph;
  logic [N-1:0]               idx;
  logic [N:0]                 rom_addr;
  logic [ROM_W-1:0]           rom_q;
  logic                       load;
  logic [PHASE_W-1:0]         mag;
  logic signed [SAMPLE_W-1:0] saw;
  logic signed [SAMPLE_W-1:0] alt;
  logic                       is_sine;
  logic                       v3_r;
  logic signed [SAMPLE_W-1:0] alt3_r;
  logic                       sine3_r;
  logic                       neg3_r;
  logic [SAMPLE_W-1:0]        rom_ext;

  assign ph   = ph_stage.phase;
  assign take = !v3_r || out_ready;
  assign load = ph_stage.valid && take;

  assign idx      = ph[PHASE_W-3 -: N];
  assign rom_addr = ph[PHASE_W-2] ? ({1'b1, {N{1'b0}}} - {1'b0, idx}) : {1'b0, idx};

  // |phase - 2^31|
  assign mag = ph[PHASE_W-1] ? {1'b0, ph[PHASE_W-2:0]} : (32'h8000_0000 - ph);
  assign saw = scale_u33({1'b0, ph});

  always_comb begin
    alt     = '0;
    is_sine = 1'b0;
    case (cfg.wave_type)
      WAVE_SQUARE: alt = (ph <= {cfg.pulse_width, 16'h0}) ? FULL_POS : FULL_NEG;
      WAVE_RISE:   alt = saw;
      WAVE_FALL:   alt = -saw;
      WAVE_TRI:    alt = scale_u33({mag, 1'b0});
      default:     is_sine = 1'b1;
    endcase
  end

  mwo_sine_rom #(
    .TBL_BITS (N)
  ) u_rom (
    .clk     (clk),
    .rd_en   (load),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (take) begin
      v3_r <= ph_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      alt3_r  <= alt;
      sine3_r <= is_sine;
      neg3_r  <= ph[PHASE_W-1];
    end
  end

  assign rom_ext    = {1'b0, rom_q};
  assign out_valid  = v3_r;
  assign out_sample = !sine3_r ? alt3_r :
                      (neg3_r ? -$signed(rom_ext) : $signed(rom_ext));
endmodule

// ===== src/mwo_checker.sv =====
// Port-level checks for the oscillator top level, with its bind.
`include "multi_waveform_oscillator_top_macros.svh"

module mwo_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mwo_pkg::SAMPLE_W-1:0] out_sample,
  input logic                              cfg_ready
);
  import mwo_pkg::*;

  // samples stay within full scale
  `MWO_ASSERT_IMP(a_sample_range, out_valid, out_sample != 16'sh8000)
  // stalled result holds
  `MWO_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_sample))
  // an empty result stage never blocks a request
  `MWO_ASSERT_IMP(a_empty_ready, !out_valid, in_ready && cfg_ready)
  // nothing comes out of the first cycle after reset
  `MWO_ASSERT_IMP(a_reset_empty, $past(!rst_n), !out_valid)
endmodule

bind multi_waveform_oscillator_top mwo_checker u_mwo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample),
  .cfg_ready  (cfg_bus.ready)
);
